// ===== rtl/bcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary command deframer package
// Shared types, flag bit positions and the frame length rule.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int BCD_MAX_FRAME_BYTES = 96;

  // Positions in the first flag word
  localparam int FLG_LINE = 0;
  localparam int FLG_M    = 1;
  localparam int FLG_G    = 2;
  localparam int FLG_X    = 3;
  localparam int FLG_Y    = 4;
  localparam int FLG_Z    = 5;
  localparam int FLG_E    = 6;
  localparam int FLG_F    = 8;
  localparam int FLG_T    = 9;
  localparam int FLG_S    = 10;
  localparam int FLG_P    = 11;
  localparam int FLG_V2   = 12;
  localparam int FLG_TEXT = 15;

  // Positions in the second flag word
  localparam int FLG2_I = 0;
  localparam int FLG2_J = 1;
  localparam int FLG2_R = 2;

  localparam int         START_BIT = 7;
  localparam logic [8:0] MOD_SUM   = 9'd255;
  localparam logic [8:0] MIN_LEN   = 9'd5;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CSUM    = 2'd1,
    STAT_BAD_LEN = 2'd2,
    STAT_NOT_BIN = 2'd3
  } bcd_status_t;

  typedef struct packed {
    bcd_status_t frame_status;
    logic [15:0] flag_word;
    logic [15:0] flag_word_two;
    logic [7:0]  frame_length;
    logic [15:0] line_number;
    logic [15:0] m_code;
    logic [15:0] g_code;
    logic [7:0]  raw_byte;
  } bcd_result_t;

  // Total frame length from both flag words and the text length byte
  function automatic logic [8:0] bcd_frame_len(input logic [15:0] f,
                                               input logic [15:0] f2,
                                               input logic [7:0]  txt);
    logic       v2;
    logic [3:0] n_quad;
    logic [3:0] n_quad2;
    logic [4:0] n_short;
    logic [8:0] n_text;
    v2 = f[FLG_V2];
    // Count the four-byte fields as independent bits, then combine
    n_quad  = ({3'b0, f[FLG_X]} + {3'b0, f[FLG_Y]}) + ({3'b0, f[FLG_Z]} + {3'b0, f[FLG_E]})
            + ({3'b0, f[FLG_F]} + {3'b0, f[FLG_S]}) + {3'b0, f[FLG_P]};
    n_quad2 = v2 ? ({3'b0, f2[FLG2_I]} + {3'b0, f2[FLG2_J]} + {3'b0, f2[FLG2_R]}) : 4'd0;
    n_short = ({3'b0, f[FLG_LINE], 1'b0} + {4'b0, f[FLG_T]})
            + (v2 ? (5'd2 + {3'b0, f[FLG_M], 1'b0} + {3'b0, f[FLG_G], 1'b0})
                  : ({4'b0, f[FLG_M]} + {4'b0, f[FLG_G]}));
    if (!f[FLG_TEXT]) n_text = 9'd0;
    else if (v2)      n_text = {1'b0, txt} + 9'd1;
    else              n_text = 9'd16;
    return (9'd4 + {3'b0, n_quad + n_quad2, 2'b00}) + ({4'b0, n_short} + n_text);
  endfunction

endpackage

// ===== rtl/binary_command_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary command deframer
// Receives command bytes, checks framing and Fletcher sums, reports frames.
// ----------------------------------------------------------------------------
// Usage:
//   in_  : one received byte per beat (valid/ready).
//   out_ : one result beat per finished frame, per rejected length and per
//          non-binary start byte; zero bytes at a frame start give nothing.
//   Each byte passes an input register and then the combinational frame logic
//   into a result register: out_valid rises once the byte that closes the
//   frame has passed both registers, and the beat leaves when out_ready is high.
//   Throughput is one byte per cycle while out_ready is high; the frame
//   logic state (position, sums, header) updates once per byte.
//   A held result stalls the frame logic; the input register still takes
//   one more byte, then in_ready drops until out_ready returns.
//   Reset puts the receiver at a frame start with both registers empty.
//   MAX_FRAME_BYTES bounds the accepted frame length and sets the width
//   of the byte position counter.
// ----------------------------------------------------------------------------
module binary_command_deframer import bcd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = BCD_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_flag_word,
  output logic [15:0] out_flag_word_two,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_line_number,
  output logic [15:0] out_m_code,
  output logic [15:0] out_g_code,
  output logic [7:0]  out_raw_byte
);

  logic        adv;
  logic        byte_vld;
  logic [7:0]  rx_byte;
  logic        res_vld;
  bcd_result_t res;
  bcd_result_t out_res;

  bcd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .byte_vld   (byte_vld),
    .rx_byte    (rx_byte)
  );

  bcd_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .rx_byte  (rx_byte),
    .adv      (adv),
    .res_vld  (res_vld),
    .res      (res)
  );

  bcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_frame_status  = out_res.frame_status;
  assign out_flag_word     = out_res.flag_word;
  assign out_flag_word_two = out_res.flag_word_two;
  assign out_frame_length  = out_res.frame_length;
  assign out_line_number   = out_res.line_number;
  assign out_m_code        = out_res.m_code;
  assign out_g_code        = out_res.g_code;
  assign out_raw_byte      = out_res.raw_byte;

endmodule

// ===== rtl/bcd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte for the frame logic; refills as it is consumed.
// ----------------------------------------------------------------------------
module bcd_in_reg import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       adv,
  output logic       byte_vld,
  output logic [7:0] rx_byte
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_ready = !vld_r || adv;
  assign vld_nxt  = in_ready ? in_valid : vld_r;
  assign byte_vld = vld_r;
  assign rx_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== rtl/bcd_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame logic
// Tracks the byte position, keeps the header, runs the mod-255 sums and
// captures the line number and codes; builds one result per finished frame,
// per rejected length and per non-binary start byte.
module bcd_frame_core import bcd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = BCD_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  rx_byte,
  input  logic        adv,
  output logic        res_vld,
  output bcd_result_t res
);

  localparam int         POS_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] exp_r, exp_nxt;
  logic [7:0]       hdr_r   [4];
  logic [7:0]       hdr_nxt [4];
  logic [7:0]       tail_r  [2];
  logic [7:0]       tail_nxt[2];
  logic [7:0]       sum_lo_r, sum_lo_nxt;
  logic [7:0]       sum_hi_r, sum_hi_nxt;
  logic [15:0]      cap_line_r, cap_line_nxt;
  logic [15:0]      cap_m_r, cap_m_nxt;
  logic [15:0]      cap_g_r, cap_g_nxt;

  logic             fire;
  logic             at_start;
  logic             in_frame;
  logic             not_bin;
  logic [POS_W-1:0] pos_inc;
  logic [15:0]      flags;
  logic [15:0]      flags2;
  logic             is_v2;
  logic [3:0]       off_line, off_m, off_g;
  logic [8:0]       frame_len;
  logic [POS_W-1:0] end_len;
  logic [7:0]       base_lo, base_hi;
  logic [8:0]       s1, s2;
  logic             at_len_byte;
  logic             len_bad;
  logic             frame_done;
  logic             csum_ok;

  always_comb begin
    fire      = byte_vld && adv;
    at_start  = (pos_r == '0);
    not_bin   = fire && at_start && (rx_byte != 8'd0) && !rx_byte[START_BIT];
    in_frame  = fire && (!at_start || rx_byte[START_BIT]);
    pos_inc   = pos_r + POS_W'(1);
    flags     = {hdr_r[1], hdr_r[0]};
    flags2    = {hdr_r[3], hdr_r[2]};
    is_v2     = flags[FLG_V2];
    frame_len = bcd_frame_len(flags, flags2, rx_byte);

    // Field offsets behind the header
    off_line = is_v2 ? (flags[FLG_TEXT] ? 4'd5 : 4'd4) : 4'd2;
    off_m    = off_line + (flags[FLG_LINE] ? 4'd2 : 4'd0);
    off_g    = off_m + (flags[FLG_M] ? (is_v2 ? 4'd2 : 4'd1) : 4'd0);

    // Mod-255 Fletcher step over the byte leaving the tail delay
    base_lo = at_start ? 8'd0 : sum_lo_r;
    base_hi = at_start ? 8'd0 : sum_hi_r;
    s1 = {1'b0, base_lo} + {1'b0, tail_r[0]};
    if (s1 >= MOD_SUM) s1 = s1 - MOD_SUM;
    s2 = {1'b0, base_hi} + s1;
    if (s2 >= MOD_SUM) s2 = s2 - MOD_SUM;

    pos_nxt      = pos_r;
    exp_nxt      = exp_r;
    hdr_nxt      = hdr_r;
    tail_nxt     = tail_r;
    sum_lo_nxt   = sum_lo_r;
    sum_hi_nxt   = sum_hi_r;
    cap_line_nxt = at_start ? 16'd0 : cap_line_r;
    cap_m_nxt    = at_start ? 16'd0 : cap_m_r;
    cap_g_nxt    = at_start ? 16'd0 : cap_g_r;

    at_len_byte = (pos_r == POS_W'(4));
    len_bad     = (frame_len < MIN_LEN) || (frame_len > MAX_LEN);
    end_len     = at_len_byte ? POS_W'(frame_len) : exp_r;
    frame_done  = 1'b0;

    if (in_frame) begin
      pos_nxt = pos_inc;
      if (pos_r < POS_W'(4)) hdr_nxt[pos_r[1:0]] = rx_byte;
      if (pos_r >= POS_W'(2)) begin
        sum_lo_nxt = s1[7:0];
        sum_hi_nxt = s2[7:0];
      end else begin
        sum_lo_nxt = base_lo;
        sum_hi_nxt = base_hi;
      end
      tail_nxt[0] = tail_r[1];
      tail_nxt[1] = rx_byte;

      // Capture fields as they pass; offsets never fall below two
      if (flags[FLG_LINE]) begin
        if (pos_r == POS_W'(off_line))         cap_line_nxt[7:0]  = rx_byte;
        if (pos_r == POS_W'(off_line + 4'd1))  cap_line_nxt[15:8] = rx_byte;
      end
      if (flags[FLG_M]) begin
        if (pos_r == POS_W'(off_m))            cap_m_nxt[7:0]     = rx_byte;
        if (is_v2 && pos_r == POS_W'(off_m + 4'd1)) cap_m_nxt[15:8] = rx_byte;
      end
      if (flags[FLG_G]) begin
        if (pos_r == POS_W'(off_g))            cap_g_nxt[7:0]     = rx_byte;
        if (is_v2 && pos_r == POS_W'(off_g + 4'd1)) cap_g_nxt[15:8] = rx_byte;
      end

      if (at_len_byte) begin
        exp_nxt = POS_W'(frame_len);
      end
      if (at_len_byte && len_bad) begin
        pos_nxt = '0;
      end else if (pos_r >= POS_W'(4) && pos_inc >= end_len) begin
        frame_done = 1'b1;
        pos_nxt    = '0;
      end
    end

    csum_ok = (tail_nxt[0] == sum_lo_nxt) && (tail_nxt[1] == sum_hi_nxt);

    res          = '0;
    res.raw_byte = rx_byte;
    res_vld      = 1'b0;
    if (not_bin) begin
      res_vld          = 1'b1;
      res.frame_status = STAT_NOT_BIN;
    end else if (in_frame && at_len_byte && len_bad) begin
      res_vld           = 1'b1;
      res.frame_status  = STAT_BAD_LEN;
      res.flag_word     = flags;
      res.flag_word_two = is_v2 ? flags2 : 16'd0;
      res.frame_length  = frame_len[8] ? 8'hFF : frame_len[7:0];
    end else if (frame_done) begin
      res_vld           = 1'b1;
      res.frame_status  = csum_ok ? STAT_OK : STAT_CSUM;
      res.flag_word     = flags;
      res.flag_word_two = is_v2 ? flags2 : 16'd0;
      res.frame_length  = 8'(end_len);
      res.line_number   = cap_line_nxt;
      res.m_code        = cap_m_nxt;
      res.g_code        = cap_g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      exp_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    tail_r     <= tail_nxt;
    sum_lo_r   <= sum_lo_nxt;
    sum_hi_r   <= sum_hi_nxt;
    cap_line_r <= cap_line_nxt;
    cap_m_r    <= cap_m_nxt;
    cap_g_r    <= cap_g_nxt;
  end

endmodule

// ===== rtl/bcd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until taken; tells the frame logic when it may move.
// ----------------------------------------------------------------------------
module bcd_out_reg import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_vld,
  input  bcd_result_t res,
  output logic        adv,
  output logic        out_valid,
  input  logic        out_ready,
  output bcd_result_t out_res
);

  logic        vld_r;
  logic        vld_nxt;
  bcd_result_t res_r;

  // Move when empty or when the held beat leaves this cycle
  assign adv       = !vld_r || out_ready;
  assign vld_nxt   = adv ? res_vld : vld_r;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

endmodule
